FILE: design/tpcc_pkg.sv
// shared constants and stage types for the two-point circle core
package tpcc_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned RAD_BITS   = 2 * COORD_BITS;
  localparam int unsigned REM_BITS   = COORD_BITS + 2;
  localparam int unsigned ROOT_STEPS = COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [RAD_BITS-1:0]   rad_t;
  typedef logic [REM_BITS-1:0]   rem_t;

  typedef struct packed {
    logic   valid;
    coord_t cx;
    coord_t cy;
    rad_t   rad;
    rem_t   rem;
    coord_t root;
  } cell_t;

endpackage

FILE: design/two_point_circle_center_radius_core.sv
// top level of the two-point circle center and radius core
// usage:
// - input channel: first_x_i, first_y_i, second_x_i, second_y_i with
//   in_valid_i / in_stall_o; a transfer happens when valid is high and
//   stall is low
// - output channel: center_x_o, center_y_o, circle_radius_o with
//   out_valid_o / out_stall_i; one result per input transfer, in order
// - each item passes through three front stages (center and differences,
//   squares, sum), then through one root cell per result bit
// - throughput is one transfer per cycle unless a valid result is stalled;
//   the front stages and root cells together hold up to 3 + COORD_BITS items
// - when the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o rises in the same cycle; a stall with no valid result
//   does not hold anything
// - reset clears all valid flags; there is no other state to clear
module two_point_circle_center_radius_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tpcc_pkg::coord_t first_x_i,
  input  tpcc_pkg::coord_t first_y_i,
  input  tpcc_pkg::coord_t second_x_i,
  input  tpcc_pkg::coord_t second_y_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tpcc_pkg::coord_t center_x_o,
  output tpcc_pkg::coord_t center_y_o,
  output tpcc_pkg::coord_t circle_radius_o
);
  import tpcc_pkg::*;

  cell_t chain [ROOT_STEPS+1];
  logic  en;

  assign en         = !(chain[ROOT_STEPS].valid && out_stall_i);
  assign in_stall_o = !en;

  tpcc_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .cell_o     (chain[0])
  );

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_cell
    tpcc_root_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  assign out_valid_o     = chain[ROOT_STEPS].valid;
  assign center_x_o      = chain[ROOT_STEPS].cx;
  assign center_y_o      = chain[ROOT_STEPS].cy;
  assign circle_radius_o = chain[ROOT_STEPS].root;

endmodule

FILE: design/tpcc_prep.sv
// front stages: center, absolute differences, squares and radicand
module tpcc_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  tpcc_pkg::coord_t first_x_i,
  input  tpcc_pkg::coord_t first_y_i,
  input  tpcc_pkg::coord_t second_x_i,
  input  tpcc_pkg::coord_t second_y_i,
  output tpcc_pkg::cell_t  cell_o
);
  import tpcc_pkg::*;

  logic [COORD_BITS:0] sum_x, sum_y;
  coord_t cx_d, cy_d, dx_d, dy_d;
  coord_t cx1_q, cy1_q, dx1_q, dy1_q;
  coord_t cx2_q, cy2_q;
  rad_t   sqx_d, sqy_d, sqx_q, sqy_q;
  logic [RAD_BITS:0] rad_sum;
  rad_t   rad_d;
  logic   v1_q, v2_q, v3_q;
  coord_t cx3_q, cy3_q;
  rad_t   rad_q;

  assign sum_x = {1'b0, first_x_i} + {1'b0, second_x_i};
  assign sum_y = {1'b0, first_y_i} + {1'b0, second_y_i};
  assign cx_d  = sum_x[COORD_BITS:1];
  assign cy_d  = sum_y[COORD_BITS:1];
  assign dx_d  = (first_x_i >= cx_d) ? (first_x_i - cx_d) : (cx_d - first_x_i);
  assign dy_d  = (first_y_i >= cy_d) ? (first_y_i - cy_d) : (cy_d - first_y_i);

  assign sqx_d = RAD_BITS'(dx1_q) * RAD_BITS'(dx1_q);
  assign sqy_d = RAD_BITS'(dy1_q) * RAD_BITS'(dy1_q);

  assign rad_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign rad_d   = rad_sum[RAD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx1_q <= cx_d;
      cy1_q <= cy_d;
      dx1_q <= dx_d;
      dy1_q <= dy_d;
      cx2_q <= cx1_q;
      cy2_q <= cy1_q;
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      cx3_q <= cx2_q;
      cy3_q <= cy2_q;
      rad_q <= rad_d;
    end
  end

  always_comb begin
    cell_o       = '0;
    cell_o.valid = v3_q;
    cell_o.cx    = cx3_q;
    cell_o.cy    = cy3_q;
    cell_o.rad   = rad_q;
  end

endmodule

FILE: design/tpcc_root_cell.sv
// one digit step of the square root chain
module tpcc_root_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  tpcc_pkg::cell_t  cell_i,
  output tpcc_pkg::cell_t  cell_o
);
  import tpcc_pkg::*;

  rem_t   rem_sh, trial;
  logic   take;
  cell_t  next_d;
  logic   valid_q;
  cell_t  data_q;

  assign rem_sh = {cell_i.rem[REM_BITS-3:0], cell_i.rad[RAD_BITS-1 -: 2]};
  assign trial  = {cell_i.root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_comb begin
    next_d       = cell_i;
    next_d.rad   = {cell_i.rad[RAD_BITS-3:0], 2'b00};
    next_d.rem   = take ? (rem_sh - trial) : rem_sh;
    next_d.root  = {cell_i.root[COORD_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= next_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

FILE: verif/tb.sv
// testbench for the two-point circle center and radius core
module tb;
  import tpcc_pkg::*;

  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned SETTLE      = 3 + COORD_BITS + 8;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t radius;
  } circle_t;

  class circle_scoreboard;
    circle_t     expected_circles[$];
    int unsigned mismatches;

    function logic [31:0] floor_root(logic [31:0] value);
      logic [31:0] rem;
      logic [31:0] trial;
      logic [31:0] rad;
      rem   = '0;
      trial = '0;
      rad   = value;
      for (int step = 0; step < 16; step++) begin
        trial = trial << 1;
        rem   = (rem << 2) | (rad >> 30);
        rad   = rad << 2;
        if (trial < rem) begin
          trial = trial + 1;
          rem   = rem - trial;
          trial = trial + 1;
        end
      end
      return trial >> 1;
    endfunction

    function void note_pair(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      logic [COORD_BITS:0] sum_x;
      logic [COORD_BITS:0] sum_y;
      coord_t              dx;
      coord_t              dy;
      logic [31:0]         dist_sq;
      logic [31:0]         root;
      circle_t             c;
      sum_x   = {1'b0, ax} + {1'b0, bx};
      sum_y   = {1'b0, ay} + {1'b0, by};
      c.cx    = sum_x[COORD_BITS:1];
      c.cy    = sum_y[COORD_BITS:1];
      dx      = (ax >= c.cx) ? ax - c.cx : c.cx - ax;
      dy      = (ay >= c.cy) ? ay - c.cy : c.cy - ay;
      dist_sq = 32'(dx) * 32'(dx) + 32'(dy) * 32'(dy);
      root    = floor_root(dist_sq);
      c.radius = root[COORD_BITS-1:0];
      expected_circles.push_back(c);
    endfunction

    function void check_circle(coord_t cx, coord_t cy, coord_t radius);
      circle_t want;
      if (expected_circles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cx=%0d cy=%0d r=%0d", cx, cy, radius);
        return;
      end
      want = expected_circles.pop_front();
      if (want.cx !== cx || want.cy !== cy || want.radius !== radius) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected cx=%0d cy=%0d r=%0d, got cx=%0d cy=%0d r=%0d",
                   want.cx, want.cy, want.radius, cx, cy, radius);
      end
    endfunction

    function int unsigned pending();
      return expected_circles.size();
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  coord_t first_x_i;
  coord_t first_y_i;
  coord_t second_x_i;
  coord_t second_y_i;
  logic   out_valid_o;
  logic   out_stall_i;
  coord_t center_x_o;
  coord_t center_y_o;
  coord_t circle_radius_o;

  circle_scoreboard board;
  bit               hold_req;
  bit               rx_gaps;
  bit               tx_gaps;
  int unsigned      stuck_cycles;

  two_point_circle_center_radius_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .center_x_o     (center_x_o),
    .center_y_o     (center_y_o),
    .circle_radius_o(circle_radius_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall bursts and the long hold
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_circle(center_x_o, center_y_o, circle_radius_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input coord_t ax, input coord_t ay,
                           input coord_t bx, input coord_t by);
    in_valid_i <= 1'b1;
    first_x_i  <= ax;
    first_y_i  <= ay;
    second_x_i <= bx;
    second_y_i <= by;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pair(ax, ay, bx, by);
  endtask

  task automatic maybe_gap();
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_random();
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    ax = coord_t'($urandom);
    ay = coord_t'($urandom);
    bx = coord_t'($urandom);
    by = coord_t'($urandom);
    if (kind >= 6 && kind <= 7) begin
      // nearby points, small radius
      bx = ax ^ coord_t'($urandom_range(0, 7));
      by = ay ^ coord_t'($urandom_range(0, 7));
    end else if (kind >= 8) begin
      ax = edge_coord();
      ay = edge_coord();
      bx = edge_coord();
      by = edge_coord();
    end
    maybe_gap();
    send_item(ax, ay, bx, by);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    board = new;
    hold_req = 1'b0;
    rx_gaps  = 1'b0;
    tx_gaps  = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    first_x_i  <= '0;
    first_y_i  <= '0;
    second_x_i <= '0;
    second_y_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, equal points and bit patterns
    send_item(12'd0,    12'd0,    12'd0,    12'd0);
    send_item(12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_item(12'd0,    12'd0,    12'd4095, 12'd4095);
    send_item(12'd4095, 12'd4095, 12'd0,    12'd0);
    send_item(12'd0,    12'd4095, 12'd4095, 12'd0);
    send_item(12'd4095, 12'd0,    12'd0,    12'd4095);
    send_item(12'd1234, 12'd2345, 12'd1234, 12'd2345);
    send_item(12'd1,    12'd0,    12'd0,    12'd0);
    send_item(12'd0,    12'd0,    12'd1,    12'd1);
    send_item(12'd1,    12'd1,    12'd0,    12'd0);
    send_item(12'd4095, 12'd2048, 12'd0,    12'd2048);
    send_item(12'd100,  12'd4095, 12'd100,  12'd0);
    send_item(12'hAAA,  12'h555,  12'h555,  12'hAAA);
    send_item(12'h555,  12'hAAA,  12'hAAA,  12'h555);
    send_item(12'd2047, 12'd2048, 12'd2048, 12'd2047);
    send_item(12'd3,    12'd4,    12'd0,    12'd0);
    send_item(12'd4094, 12'd4095, 12'd4095, 12'd4094);
    send_item(12'd0,    12'd4095, 12'd0,    12'd4095);
    wait_drained();

    rx_gaps = 1'b1;
    tx_gaps = 1'b1;
    repeat (250) send_random();

    // receiver holds off while items keep coming
    tx_gaps  = 1'b0;
    hold_req = 1'b1;
    repeat (60) send_random();
    wait_drained();
    repeat ($urandom_range(1, 7)) @(posedge clk_i);

    rx_gaps = 1'b0;
    tx_gaps = 1'b1;
    repeat (150) send_random();
    rx_gaps = 1'b1;
    tx_gaps = 1'b0;
    repeat (150) send_random();
    rx_gaps = 1'b0;
    repeat (120) send_random();

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
